>>> design/scan_disk_scheduler_unit_macros.svh
// assertion helpers shared by the scheduler modules
`ifndef SCAN_DISK_SCHEDULER_UNIT_MACROS_SVH
`define SCAN_DISK_SCHEDULER_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define SDS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sds_pkg.sv
package sds_pkg;

   // store and field sizes
   localparam int MAX_REQ    = 32;
   localparam int CYL_W      = 16;
   localparam int CNT_W      = $clog2(MAX_REQ + 1);
   localparam int IDX_W      = $clog2(MAX_REQ);
   localparam int DS_W       = 17;
   localparam int TOT_W      = 17;
   localparam int SUM_W      = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CYL_W-1:0] CYL_MAX      = '1;
   localparam logic [TOT_W-1:0] TOT_MAX      = '1;
   localparam logic [DS_W-1:0]  DISK_SIZE_RST = DS_W'(200);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_HEAD = 2'd0,
      CSR_DISK_SIZE    = 2'd1,
      CSR_SWEEP_UP     = 2'd2
   } csr_index_type;

   // what the datapath fetches for the next visit
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_UP   = 2'd1,
      OP_DN   = 2'd2,
      OP_TURN = 2'd3
   } fetch_op_type;

   // controller to datapath
   typedef struct packed {
      logic         insert;
      logic         start;
      logic         scan;
      logic         read_dn;
      fetch_op_type op;
      logic         last;
      logic         send;
      logic         finish;
   } sds_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic up_left;
      logic dn_left;
      logic up_last;
      logic dn_last;
      logic sweep_up;
      logic out_free;
      logic pend_last;
   } sds_sts_type;

endpackage

>>> design/scan_disk_scheduler_unit.sv
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | request_cylinder, batch_end
// rsp     | out | rsp_valid/rsp_ready  | served_cylinder, edge_turn, movement_total,
//         |     |                      | dropped, final_visit
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// requests load one per cycle into a sorted cell row; the last one of a batch
// then starts a scan past each request below the head to find the split,
// and every visit goes through a fetch step, then a send step in the sequencer
// reset is synchronous and clears control state; the store needs no clearing
// while results of a batch are sent no request is taken; the next batch loads
// as soon as the final visit sits in the result register
// a stalled rsp holds the sequencer in its send step
module scan_disk_scheduler_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sds_pkg::CYL_W-1:0]       req_request_cylinder,
   input  logic                            req_batch_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sds_pkg::CYL_W-1:0]       rsp_served_cylinder,
   output logic                            rsp_edge_turn,
   output logic [sds_pkg::TOT_W-1:0]       rsp_movement_total,
   output logic                            rsp_dropped,
   output logic                            rsp_final_visit,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sds_pkg::CSR_DATA_W-1:0]  csr_data
);

   sds_pkg::sds_cmd_type cmd;
   sds_pkg::sds_sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   sds_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_batch_end (req_batch_end),
      .req_ready     (req_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   sds_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_request_cylinder (req_request_cylinder),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_served_cylinder  (rsp_served_cylinder),
      .rsp_edge_turn        (rsp_edge_turn),
      .rsp_movement_total   (rsp_movement_total),
      .rsp_dropped          (rsp_dropped),
      .rsp_final_visit      (rsp_final_visit)
   );

endmodule

>>> design/sds_sort_row.sv
// row of cells that keeps the batch sorted ascending as requests arrive
module sds_sort_row (
   input  logic                        clock,
   input  logic                        ins_en,
   input  logic [sds_pkg::CYL_W-1:0]   ins_value,
   input  logic [sds_pkg::CNT_W-1:0]   count,
   input  logic [sds_pkg::IDX_W-1:0]   rd_idx,
   output logic [sds_pkg::CYL_W-1:0]   rd_data
);

   logic [sds_pkg::CYL_W-1:0] cell_ff [sds_pkg::MAX_REQ];
   logic [sds_pkg::MAX_REQ-1:0] gt;

   // each cell compares its value with the incoming one
   always_comb begin
      for (int i = 0; i < sds_pkg::MAX_REQ; i++) begin
         gt[i] = (sds_pkg::CNT_W'(i) < count) && (cell_ff[i] > ins_value);
      end
   end

   // cells above the insert point shift up by one, the gap takes the new value
   for (genvar g = 0; g < sds_pkg::MAX_REQ; g++) begin : g_cell
      if (g == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (ins_en && (gt[g] || count == sds_pkg::CNT_W'(g))) begin
               cell_ff[g] <= ins_value;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (ins_en && (gt[g] || count == sds_pkg::CNT_W'(g))) begin
               cell_ff[g] <= gt[g-1] ? cell_ff[g-1] : ins_value;
            end
         end
      end
   end

   // single read port
   assign rd_data = cell_ff[rd_idx];

endmodule

>>> design/sds_ctrl.sv
// sequencer: loading, lower-set count, then fetch and send of each visit
module sds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_batch_end,
   output logic                 req_ready,
   input  sds_pkg::sds_sts_type sts,
   output sds_pkg::sds_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_LOAD  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_FETCH = 2'd2,
      ST_SEND  = 2'd3
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;
   logic      ready_ff, ready_in;
   logic      prim_left, other_left, prim_last, other_last;

   assign req_ready = ready_ff;

   // first set is the one in the sweep direction
   always_comb begin
      prim_left  = sts.sweep_up ? sts.up_left : sts.dn_left;
      other_left = sts.sweep_up ? sts.dn_left : sts.up_left;
      prim_last  = sts.sweep_up ? sts.up_last : sts.dn_last;
      other_last = sts.sweep_up ? sts.dn_last : sts.up_last;
   end

   // next state and commands
   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      second_in   = second_ff;
      ready_in    = ready_ff;
      cmd.insert  = ready_ff && req_valid;
      cmd.read_dn = (state_ff == ST_FETCH) && (second_ff == sts.sweep_up);
      unique case (state_ff)
         ST_LOAD: begin
            if (ready_ff && req_valid && req_batch_end) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
               ready_in  = 1'b0;
               second_in = 1'b0;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (!second_ff) begin
               if (prim_left) begin
                  cmd.op   = sts.sweep_up ? sds_pkg::OP_UP : sds_pkg::OP_DN;
                  cmd.last = prim_last && !other_left;
               end else begin
                  cmd.op    = sds_pkg::OP_TURN;
                  second_in = 1'b1;
               end
            end else begin
               cmd.op   = sts.sweep_up ? sds_pkg::OP_DN : sds_pkg::OP_UP;
               cmd.last = other_last;
            end
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (sts.out_free) begin
               cmd.send = 1'b1;
               if (sts.pend_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_LOAD;
                  ready_in   = 1'b1;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
            ready_in = 1'b1;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         second_ff <= 1'b0;
         ready_ff  <= 1'b1;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
         ready_ff  <= ready_in;
      end
   end

`include "scan_disk_scheduler_unit_macros.svh"

   `SDS_ASSERT_NEXT(a_last_to_load, (state_ff == ST_SEND) && sts.out_free && sts.pend_last, (state_ff == ST_LOAD) && ready_ff, "last visit did not return to loading")
   `SDS_ASSERT_NOW(a_turn_not_last, cmd.op == sds_pkg::OP_TURN, !cmd.last, "edge turn marked as final visit")
   `SDS_ASSERT_NOW(a_busy_not_ready, state_ff != ST_LOAD, !ready_ff, "request taken while scheduling")

endmodule

>>> design/sds_dpath.sv
// datapath: config, sorted store, pointers, arm position, movement sum, result register
module sds_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  sds_pkg::sds_cmd_type            cmd,
   output sds_pkg::sds_sts_type            sts,
   input  logic [sds_pkg::CYL_W-1:0]       req_request_cylinder,
   input  logic                            csr_valid,
   input  logic [sds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sds_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [sds_pkg::CYL_W-1:0]       rsp_served_cylinder,
   output logic                            rsp_edge_turn,
   output logic [sds_pkg::TOT_W-1:0]       rsp_movement_total,
   output logic                            rsp_dropped,
   output logic                            rsp_final_visit
);

   localparam int CNT_W = sds_pkg::CNT_W;
   localparam int CYL_W = sds_pkg::CYL_W;

   logic [CYL_W-1:0]           head_ff;
   logic [sds_pkg::DS_W-1:0]   dsize_ff;
   logic                       sweep_ff;
   logic [CNT_W-1:0]           cnt_ff, up_ff, dn_ff, dn_prev;
   logic                       ovf_ff, full, out_free;
   logic [sds_pkg::IDX_W-1:0]  rd_idx;
   logic [CYL_W-1:0]           rd_data, edge_pos, next_cyl, move_len;
   logic [sds_pkg::DS_W-1:0]   ds_m1;
   logic [CYL_W-1:0]           arm_ff, cyl_ff, dist_ff;
   logic                       turn_ff, last_ff;
   logic [sds_pkg::SUM_W-1:0]  sum_ff, sum_new;
   logic                       rsp_valid_ff;
   logic [CYL_W-1:0]           rsp_cyl_ff;
   logic                       rsp_turn_ff, rsp_drop_ff, rsp_final_ff;
   logic [sds_pkg::TOT_W-1:0]  rsp_tot_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         dsize_ff <= sds_pkg::DISK_SIZE_RST;
         sweep_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            sds_pkg::CSR_INITIAL_HEAD: head_ff  <= csr_data[CYL_W-1:0];
            sds_pkg::CSR_DISK_SIZE:    dsize_ff <= csr_data[sds_pkg::DS_W-1:0];
            sds_pkg::CSR_SWEEP_UP:     sweep_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sorted request store
   assign full = (cnt_ff == CNT_W'(sds_pkg::MAX_REQ));

   sds_sort_row u_row (
      .clock     (clock),
      .ins_en    (cmd.insert && !full),
      .ins_value (req_request_cylinder),
      .count     (cnt_ff),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data)
   );

   // read address: descending pointer reads the entry below it
   always_comb begin
      dn_prev = dn_ff - 1'b1;
      rd_idx  = cmd.read_dn ? dn_prev[sds_pkg::IDX_W-1:0] : up_ff[sds_pkg::IDX_W-1:0];
   end

   // top edge, clamped to the largest cylinder
   always_comb begin
      ds_m1 = (dsize_ff == '0) ? '0 : dsize_ff - 1'b1;
      if (ds_m1 > sds_pkg::DS_W'(sds_pkg::CYL_MAX)) begin
         edge_pos = sds_pkg::CYL_MAX;
      end else begin
         edge_pos = ds_m1[CYL_W-1:0];
      end
   end

   // next visit and its distance from the arm
   always_comb begin
      if (cmd.op == sds_pkg::OP_TURN) begin
         next_cyl = sweep_ff ? edge_pos : '0;
      end else begin
         next_cyl = rd_data;
      end
      move_len = (next_cyl > arm_ff) ? next_cyl - arm_ff : arm_ff - next_cyl;
      sum_new  = sum_ff + sds_pkg::SUM_W'(dist_ff);
   end

   // fill count and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.finish) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.insert) begin
         if (full) begin
            ovf_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // pointers: up walks from the first upper entry, dn from it downwards
   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff <= '0;
         dn_ff <= '0;
      end else if (cmd.start) begin
         up_ff <= '0;
      end else if (cmd.scan) begin
         if (sts.scan_done) begin
            dn_ff <= up_ff;
         end else begin
            up_ff <= up_ff + 1'b1;
         end
      end else begin
         case (cmd.op)
            sds_pkg::OP_UP: up_ff <= up_ff + 1'b1;
            sds_pkg::OP_DN: dn_ff <= dn_prev;
            default: ;
         endcase
      end
   end

   // arm position and movement sum
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.start) begin
         arm_ff <= head_ff;
         sum_ff <= '0;
      end else begin
         if (cmd.op != sds_pkg::OP_NONE) begin
            arm_ff <= next_cyl;
         end
         if (cmd.send) begin
            sum_ff <= sum_new;
         end
      end
   end

   // fetched visit
   always_ff @(posedge clock) begin
      if (cmd.op != sds_pkg::OP_NONE) begin
         cyl_ff  <= next_cyl;
         dist_ff <= move_len;
         turn_ff <= (cmd.op == sds_pkg::OP_TURN);
         last_ff <= cmd.last;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.send) begin
         rsp_cyl_ff   <= cyl_ff;
         rsp_turn_ff  <= turn_ff;
         rsp_drop_ff  <= ovf_ff;
         rsp_final_ff <= last_ff;
         if (sum_new > sds_pkg::SUM_W'(sds_pkg::TOT_MAX)) begin
            rsp_tot_ff <= sds_pkg::TOT_MAX;
         end else begin
            rsp_tot_ff <= sum_new[sds_pkg::TOT_W-1:0];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_served_cylinder = rsp_cyl_ff;
   assign rsp_edge_turn       = rsp_turn_ff;
   assign rsp_movement_total  = rsp_tot_ff;
   assign rsp_dropped         = rsp_drop_ff;
   assign rsp_final_visit     = rsp_final_ff;

   // status back to the controller
   always_comb begin
      sts.scan_done = (up_ff == cnt_ff) || (rd_data >= head_ff);
      sts.up_left   = (up_ff != cnt_ff);
      sts.dn_left   = (dn_ff != '0);
      sts.up_last   = ((up_ff + 1'b1) == cnt_ff);
      sts.dn_last   = (dn_ff == CNT_W'(1));
      sts.sweep_up  = sweep_ff;
      sts.out_free  = out_free;
      sts.pend_last = last_ff;
   end

`include "scan_disk_scheduler_unit_macros.svh"

   `SDS_ASSERT_NOW(a_count_range, 1'b1, cnt_ff <= CNT_W'(sds_pkg::MAX_REQ), "fill count beyond store")
   `SDS_ASSERT_NOW(a_up_in_range, cmd.op == sds_pkg::OP_UP, up_ff < cnt_ff, "ascending read past batch")
   `SDS_ASSERT_NOW(a_dn_nonzero, cmd.op == sds_pkg::OP_DN, dn_ff != '0, "descending read below entry zero")
   `SDS_ASSERT_NOW(a_send_free, cmd.send, out_free, "result register overwritten")

endmodule
